// ===== rtl/tlpc_pkg.sv =====
// Types and constants shared by the tank level pump controller.
// No dependencies; compile first.
package tlpc_pkg;

	localparam int SAMPLE_FIELDS = 5;
	localparam int MV_W          = 12;
	localparam int PCT_W         = 7;
	localparam int LEVEL_W       = 10;
	localparam int SUM_W         = 15;
	localparam int NUM_W         = 24;
	localparam int DEN_W         = 16;
	localparam int QUOT_W        = 21;
	localparam int DMAG_W        = 15;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 12;
	localparam int CMP_W         = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_LOW    = 3'd0,
		CFG_LEVEL_HIGH   = 3'd1,
		CFG_REFILL_START = 3'd2,
		CFG_REFILL_SPLIT = 3'd3,
		CFG_SENSOR_LOW   = 3'd4,
		CFG_SENSOR_HIGH  = 3'd5,
		CFG_MOIST_OVR    = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LOW   = 2'd1,
		ERR_HIGH  = 2'd2,
		ERR_FAULT = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MV_W-1:0] sample_a;
		logic [MV_W-1:0] sample_b;
		logic [MV_W-1:0] sample_c;
		logic [MV_W-1:0] sample_d;
		logic [MV_W-1:0] sample_e;
		logic            moisture_alarm;
	} tlpc_in_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level_percent;
		logic                      main_pump_on;
		logic                      main_pump_forced;
		logic                      refill_pump_first;
		logic                      refill_pump_second;
		logic                      filling;
		logic [1:0]                error_class;
		logic                      error_urgent;
	} tlpc_out_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage

// ===== rtl/tlpc_ifs.sv =====
// Valid/ready channels for sensor items and controller results.
// Depends on tlpc_pkg.
interface tlpc_in_if import tlpc_pkg::*; ();
	logic     valid;
	logic     ready;
	tlpc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlpc_out_if import tlpc_pkg::*; ();
	logic      valid;
	logic      ready;
	tlpc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tank_level_pump_controller_top.sv =====
// Tank level pump controller: averages level sensor samples to a fill
// percent and runs refill and delivery pump control.
// Depends on tlpc_pkg, tlpc_ifs and tlpc_div.
//
// Use: one sensor item per tick enters on the sensor channel (valid/ready);
// one result item per sensor item leaves on the result channel.
// The percent comes from a serial divider yielding one quotient bit per
// cycle over 21 bits; an item passes setup, division (skipped when the
// sensor voltages are equal, a sensor fault) and the final state to the
// result register; a new item is taken in the cycle after a result is loaded.
// sensor.ready is high only while the sequencer waits for an item.
// The result register holds its item until taken; while it is full the
// next sensor item is still accepted and worked on, and its result waits
// in the final state until the register frees.
// Configuration registers are written through cfg_we/cfg_index/cfg_data by
// the user only while the block is idle; the block does not enforce this.
// Unknown indexes are ignored. Reset loads the configuration defaults,
// clears the pump and fill state and empties the result register.
module tank_level_pump_controller_top import tlpc_pkg::*; #(
	parameter int SAMPLES_PER_TICK = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tlpc_in_if.sink               sensor,
	tlpc_out_if.source            result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NEFF = (SAMPLES_PER_TICK > SAMPLE_FIELDS) ? SAMPLE_FIELDS :
		((SAMPLES_PER_TICK < 1) ? 1 : SAMPLES_PER_TICK);

	// configuration
	logic [PCT_W-1:0] level_low_q, level_high_q, refill_start_q, refill_split_q;
	logic [MV_W-1:0]  sensor_low_q, sensor_high_q;
	logic             moist_ovr_q;

	// control state
	state_t state_q, state_d;
	logic   fill_q, pump1_q, pump2_q, main_q, forced_q;
	logic   out_valid_q;
	tlpc_out_t out_q;

	// item payload
	logic [MV_W-1:0]           smp_q [SAMPLE_FIELDS];
	logic                      moist_q;
	logic signed [LEVEL_W-1:0] p_q;
	logic                      num_neg_q;

	// datapath
	logic [SUM_W-1:0]          sum;
	logic [SUM_W-1:0]          nlow;
	logic signed [SUM_W+1:0]   diff;
	logic signed [NUM_W-1:0]   num;
	logic signed [MV_W:0]      span;
	logic signed [DEN_W-1:0]   den;
	logic [QUOT_W-1:0]         num_mag;
	logic [DMAG_W-1:0]         den_mag;
	logic                      fault;
	logic [QUOT_W-1:0]         quot;
	div_ctl_t                  div_in, div_out;
	logic                      fire;
	logic                      load;
	logic signed [LEVEL_W-1:0] p_sat;

	// decisions
	logic signed [CMP_W-1:0] px, lh, lh5, ll, lrs, lsplit;
	logic                    moist_block;
	logic                    fill_d, pump1_d, pump2_d, main_d, forced_d;
	err_t                    err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_low_q    <= PCT_W'(30);
			level_high_q   <= PCT_W'(80);
			refill_start_q <= PCT_W'(50);
			refill_split_q <= PCT_W'(15);
			sensor_low_q   <= MV_W'(900);
			sensor_high_q  <= MV_W'(1900);
			moist_ovr_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL_LOW:    level_low_q    <= cfg_data[PCT_W-1:0];
				CFG_LEVEL_HIGH:   level_high_q   <= cfg_data[PCT_W-1:0];
				CFG_REFILL_START: refill_start_q <= cfg_data[PCT_W-1:0];
				CFG_REFILL_SPLIT: refill_split_q <= cfg_data[PCT_W-1:0];
				CFG_SENSOR_LOW:   sensor_low_q   <= cfg_data;
				CFG_SENSOR_HIGH:  sensor_high_q  <= cfg_data;
				CFG_MOIST_OVR:    moist_ovr_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// operand setup
	always_comb begin
		sum = '0;
		for (int i = 0; i < NEFF; i++) begin
			sum = sum + SUM_W'(smp_q[i]);
		end
	end

	assign nlow    = SUM_W'(NEFF) * SUM_W'(sensor_low_q);
	assign diff    = $signed({2'b00, sum}) - $signed({2'b00, nlow});
	assign num     = NUM_W'(diff) * NUM_W'(100);
	assign span    = $signed({1'b0, sensor_high_q}) - $signed({1'b0, sensor_low_q});
	assign den     = DEN_W'(span) * DEN_W'(NEFF);
	assign num_mag = num[NUM_W-1] ? QUOT_W'(-num) : QUOT_W'(num);
	assign den_mag = den[DEN_W-1] ? DMAG_W'(-den) : DMAG_W'(den);
	assign fault   = (sensor_high_q == sensor_low_q);

	assign div_in.start = (state_q == ST_SETUP) && !fault;
	assign div_in.done  = 1'b0;

	tlpc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (div_in),
		.num     (num_mag),
		.den     (den_mag),
		.ctl_out (div_out),
		.quot    (quot)
	);

	always_comb begin
		if (num_neg_q) begin
			p_sat = (quot > QUOT_W'(512)) ? LEVEL_W'(-512) : -$signed(LEVEL_W'(quot));
		end else begin
			p_sat = (quot > QUOT_W'(511)) ? LEVEL_W'(511) : $signed(LEVEL_W'(quot));
		end
	end

	// sequencer
	assign fire = !out_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (sensor.valid) state_d = ST_SETUP;
			ST_SETUP: state_d = fault ? ST_DONE : ST_DIV;
			ST_DIV:   if (div_out.done) state_d = ST_DONE;
			ST_DONE:  if (fire) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sensor.ready = (state_q == ST_IDLE);
		load         = (state_q == ST_DONE) && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			smp_q[0] <= sensor.data.sample_a;
			smp_q[1] <= sensor.data.sample_b;
			smp_q[2] <= sensor.data.sample_c;
			smp_q[3] <= sensor.data.sample_d;
			smp_q[4] <= sensor.data.sample_e;
			moist_q  <= sensor.data.moisture_alarm;
		end
		if (state_q == ST_SETUP) begin
			num_neg_q <= num[NUM_W-1] ^ den[DEN_W-1];
			if (fault) p_q <= '0;
		end
		if (div_out.done) begin
			p_q <= p_sat;
		end
	end

	// pump and error decisions
	assign px          = CMP_W'(p_q);
	assign lh          = $signed({4'b0000, level_high_q});
	assign lh5         = lh - CMP_W'(5);
	assign ll          = $signed({4'b0000, level_low_q});
	assign lrs         = $signed({4'b0000, refill_start_q});
	assign lsplit      = ll + $signed({4'b0000, refill_split_q});
	assign moist_block = moist_q && !moist_ovr_q;

	always_comb begin
		fill_d   = fill_q;
		pump1_d  = pump1_q;
		pump2_d  = pump2_q;
		main_d   = main_q;
		forced_d = forced_q;
		err_d    = ERR_NONE;
		if (!fault && px >= 0 && px < lh) begin
			if (px > ll) begin
				err_d    = ERR_NONE;
				main_d   = !moist_block;
				forced_d = 1'b0;
				if (fill_q && px >= lh5) begin
					pump1_d = 1'b0;
					pump2_d = 1'b0;
					fill_d  = 1'b0;
				end else if (fill_q || px < lrs) begin
					fill_d = 1'b1;
					if (moist_block) begin
						pump1_d = 1'b0;
						pump2_d = 1'b0;
					end else if (px <= lsplit) begin
						pump1_d = 1'b1;
					end else begin
						pump2_d = 1'b1;
					end
				end
			end else begin
				err_d    = ERR_LOW;
				main_d   = 1'b0;
				forced_d = 1'b0;
			end
		end else begin
			pump1_d = 1'b0;
			pump2_d = 1'b0;
			if (!fault && px >= 0) begin
				err_d    = ERR_HIGH;
				main_d   = 1'b1;
				forced_d = 1'b1;
			end else begin
				err_d    = ERR_FAULT;
				main_d   = 1'b0;
				forced_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 1'b0;
			pump1_q     <= 1'b0;
			pump2_q     <= 1'b0;
			main_q      <= 1'b0;
			forced_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				fill_q      <= fill_d;
				pump1_q     <= pump1_d;
				pump2_q     <= pump2_d;
				main_q      <= main_d;
				forced_q    <= forced_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.level_percent      <= p_q;
			out_q.main_pump_on       <= main_d;
			out_q.main_pump_forced   <= forced_d;
			out_q.refill_pump_first  <= pump1_d;
			out_q.refill_pump_second <= pump2_d;
			out_q.filling            <= fill_d;
			out_q.error_class        <= err_d;
			out_q.error_urgent       <= err_d[1];
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_forced_high: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.main_pump_forced |->
			result.data.main_pump_on && result.data.error_class == ERR_HIGH)
		else $error("forced main pump without too-high error");

	a_fault_off: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.error_class == ERR_FAULT |->
			!result.data.main_pump_on && !result.data.refill_pump_first &&
			!result.data.refill_pump_second)
		else $error("pumps running on sensor fault");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_out.done |-> state_q == ST_DIV)
		else $error("divider finished outside division phase");

	a_load_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result item appeared without a finished item");

endmodule

// ===== rtl/tlpc_div.sv =====
// Restoring serial divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on tlpc_pkg.
module tlpc_div import tlpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  div_ctl_t            ctl_in,
	input  logic [QUOT_W-1:0]   num,
	input  logic [DMAG_W-1:0]   den,
	output div_ctl_t            ctl_out,
	output logic [QUOT_W-1:0]   quot
);

	localparam int CNT_W = $clog2(QUOT_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [DMAG_W-1:0]  rem_q;
	logic [DMAG_W-1:0]  den_q;
	logic [DMAG_W:0]    shifted;
	logic [DMAG_W+1:0]  trial;
	logic               qbit;

	assign shifted = {rem_q, quot_q[QUOT_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = ~trial[DMAG_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= {quot_q[QUOT_W-2:0], qbit};
			rem_q  <= qbit ? trial[DMAG_W-1:0] : shifted[DMAG_W-1:0];
		end
	end

	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;
	assign quot          = quot_q;

endmodule

// ===== tb/tb_tank_level_pump_controller_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the tank level pump controller: directed sensor items,
// then random level walks under several register settings, with random stalls.
// Depends on tlpc_pkg, tlpc_ifs and tank_level_pump_controller_top.
module tb_tank_level_pump_controller_top;
	import tlpc_pkg::*;

	localparam int TICK_SAMPLES = 5;
	localparam int USED_SAMPLES = TICK_SAMPLES > SAMPLE_FIELDS ? SAMPLE_FIELDS :
		(TICK_SAMPLES < 1 ? 1 : TICK_SAMPLES);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam int SAT_HI = 511;
	localparam int SAT_LO = -512;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int END_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS = 60;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		logic [PCT_W-1:0] level_low;
		logic [PCT_W-1:0] level_high;
		logic [PCT_W-1:0] refill_start;
		logic [PCT_W-1:0] refill_split;
		logic [MV_W-1:0]  sensor_low_mv;
		logic [MV_W-1:0]  sensor_high_mv;
		logic             moist_ovr;
	} tank_cfg_t;

	typedef struct {
		int        cfg_sel;
		tlpc_in_t  item;
		bit        typed;
		tlpc_out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tlpc_in_if  sensor_if ();
	tlpc_out_if result_if ();

	tank_level_pump_controller_top #(.SAMPLES_PER_TICK(TICK_SAMPLES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tank_cfg_t model_cfg;
	logic tank_filling = 1'b0;
	logic pump_first = 1'b0;
	logic pump_second = 1'b0;
	logic main_pump = 1'b0;
	logic main_forced = 1'b0;

	tlpc_out_t pending_results[$];
	dir_row_t dir_rows[$];
	tank_cfg_t dir_cfg[7];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit hold_req = 1'b0;
	bit steady = 1'b0;

	function automatic tank_cfg_t cfg_of(int lo, int hi, int start, int split,
			int lmv, int hmv, int ovr);
		tank_cfg_t c;
		c.level_low = PCT_W'(lo);
		c.level_high = PCT_W'(hi);
		c.refill_start = PCT_W'(start);
		c.refill_split = PCT_W'(split);
		c.sensor_low_mv = MV_W'(lmv);
		c.sensor_high_mv = MV_W'(hmv);
		c.moist_ovr = ovr[0];
		return c;
	endfunction

	function automatic void refill_step(int pct, logic blocked);
		if (blocked) begin
			pump_first = 1'b0;
			pump_second = 1'b0;
		end else if (pct <= int'(model_cfg.level_low) + int'(model_cfg.refill_split)) begin
			pump_first = 1'b1;
		end else begin
			pump_second = 1'b1;
		end
	endfunction

	function automatic tlpc_out_t predict_tick(tlpc_in_t it);
		tlpc_out_t r;
		logic [MV_W-1:0] s [SAMPLE_FIELDS];
		longint sum, num, den, q;
		int pct;
		logic fault, blocked;
		err_t err;
		s = '{it.sample_a, it.sample_b, it.sample_c, it.sample_d, it.sample_e};
		sum = 0;
		for (int i = 0; i < USED_SAMPLES; i++)
			sum += longint'(s[i]);
		pct = 0;
		fault = (model_cfg.sensor_high_mv == model_cfg.sensor_low_mv);
		if (!fault) begin
			num = 100 * (sum - USED_SAMPLES * longint'(model_cfg.sensor_low_mv));
			den = USED_SAMPLES * (longint'(model_cfg.sensor_high_mv) -
				longint'(model_cfg.sensor_low_mv));
			q = num / den;
			if (q > SAT_HI) q = longint'(SAT_HI);
			if (q < SAT_LO) q = longint'(SAT_LO);
			pct = int'(q);
		end
		blocked = it.moisture_alarm && !model_cfg.moist_ovr;
		if (!fault && pct >= 0 && pct < int'(model_cfg.level_high)) begin
			if (pct > int'(model_cfg.level_low)) begin
				err = ERR_NONE;
				if (tank_filling) begin
					if (pct >= int'(model_cfg.level_high) - 5) begin
						pump_first = 1'b0;
						pump_second = 1'b0;
						tank_filling = 1'b0;
					end else begin
						refill_step(pct, blocked);
					end
				end else if (pct < int'(model_cfg.refill_start)) begin
					tank_filling = 1'b1;
					refill_step(pct, blocked);
				end
				main_pump = !blocked;
				main_forced = 1'b0;
			end else begin
				err = ERR_LOW;
				main_pump = 1'b0;
				main_forced = 1'b0;
			end
		end else begin
			if (!fault && pct >= 0) begin
				err = ERR_HIGH;
				main_pump = 1'b1;
				main_forced = 1'b1;
			end else begin
				err = ERR_FAULT;
				main_pump = 1'b0;
				main_forced = 1'b0;
			end
			pump_first = 1'b0;
			pump_second = 1'b0;
		end
		r.level_percent = LEVEL_W'(pct);
		r.main_pump_on = main_pump;
		r.main_pump_forced = main_forced;
		r.refill_pump_first = pump_first;
		r.refill_pump_second = pump_second;
		r.filling = tank_filling;
		r.error_class = err;
		r.error_urgent = (err == ERR_HIGH) || (err == ERR_FAULT);
		return r;
	endfunction

	function automatic tlpc_out_t outcome(int lvl, bit mp, bit mf, bit p1, bit p2, bit fl,
			err_t e);
		tlpc_out_t r;
		r.level_percent = LEVEL_W'(lvl);
		r.main_pump_on = mp;
		r.main_pump_forced = mf;
		r.refill_pump_first = p1;
		r.refill_pump_second = p2;
		r.filling = fl;
		r.error_class = e;
		r.error_urgent = (e == ERR_HIGH) || (e == ERR_FAULT);
		return r;
	endfunction

	function automatic tlpc_in_t flat(int mv, bit m);
		tlpc_in_t it;
		it.sample_a = MV_W'(mv);
		it.sample_b = MV_W'(mv);
		it.sample_c = MV_W'(mv);
		it.sample_d = MV_W'(mv);
		it.sample_e = MV_W'(mv);
		it.moisture_alarm = m;
		return it;
	endfunction

	function automatic tlpc_in_t near_level(int pct, bit m);
		tlpc_in_t it;
		int base, v;
		int s [SAMPLE_FIELDS];
		base = int'(model_cfg.sensor_low_mv) + (int'(model_cfg.sensor_high_mv) -
			int'(model_cfg.sensor_low_mv)) * pct / 100;
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			v = base + int'($urandom_range(0, 16)) - 8;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			s[i] = v;
		end
		it.sample_a = MV_W'(s[0]);
		it.sample_b = MV_W'(s[1]);
		it.sample_c = MV_W'(s[2]);
		it.sample_d = MV_W'(s[3]);
		it.sample_e = MV_W'(s[4]);
		it.moisture_alarm = m;
		return it;
	endfunction

	function automatic tank_cfg_t random_cfg();
		tank_cfg_t c;
		logic [MV_W-1:0] t;
		if ($urandom_range(0, 3) == 0) begin
			c = tank_cfg_t'({$urandom, $urandom});
			if ($urandom_range(0, 5) == 0)
				c.sensor_high_mv = c.sensor_low_mv;
		end else begin
			c.level_high = PCT_W'($urandom_range(50, 85));
			c.level_low = PCT_W'($urandom_range(25, int'(c.level_high) - 10));
			c.refill_start = PCT_W'($urandom_range(int'(c.level_low), int'(c.level_high)));
			c.refill_split = PCT_W'($urandom_range(0, 30));
			c.sensor_low_mv = MV_W'($urandom_range(0, 1500));
			c.sensor_high_mv = MV_W'($urandom_range(int'(c.sensor_low_mv) + 100, 3300));
			c.moist_ovr = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) begin
				t = c.sensor_low_mv;
				c.sensor_low_mv = c.sensor_high_mv;
				c.sensor_high_mv = t;
			end
		end
		return c;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] reg_image(tank_cfg_t c, int k);
		case (CFG_IDX_W'(k))
			CFG_LEVEL_LOW:    return {5'($urandom), c.level_low};
			CFG_LEVEL_HIGH:   return {5'($urandom), c.level_high};
			CFG_REFILL_START: return {5'($urandom), c.refill_start};
			CFG_REFILL_SPLIT: return {5'($urandom), c.refill_split};
			CFG_SENSOR_LOW:   return c.sensor_low_mv;
			CFG_SENSOR_HIGH:  return c.sensor_high_mv;
			CFG_MOIST_OVR:    return {11'($urandom), c.moist_ovr};
			default:          return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t %s: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic add_row(int sel, tlpc_in_t it, bit typed, tlpc_out_t want);
		dir_row_t row;
		row.cfg_sel = sel;
		row.item = it;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input tlpc_in_t it, input bit typed, input tlpc_out_t want);
		int gap;
		tlpc_out_t predicted;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			sensor_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensor_if.valid <= 1'b1;
		sensor_if.data <= it;
		do @(posedge clk); while (!sensor_if.ready);
		predicted = predict_tick(it);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain();
		sensor_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input tank_cfg_t c);
		for (int k = 0; k <= int'(CFG_SPARE); k++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(k);
			cfg_data <= reg_image(c, k);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		model_cfg = c;
		@(posedge clk);
	endtask

	// result side: random back-pressure, one long hold on request
	initial begin
		result_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				result_if.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				result_if.ready <= 1'b0;
				repeat (pause_len() + 1) @(posedge clk);
			end else begin
				result_if.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result item: expected none, got %h", $time,
						result_if.data);
			end else begin
				check_field("level_percent", int'($signed(pending_results[0].level_percent)),
					int'($signed(result_if.data.level_percent)));
				check_field("main_pump_on", int'(pending_results[0].main_pump_on),
					int'(result_if.data.main_pump_on));
				check_field("main_pump_forced", int'(pending_results[0].main_pump_forced),
					int'(result_if.data.main_pump_forced));
				check_field("refill_pump_first", int'(pending_results[0].refill_pump_first),
					int'(result_if.data.refill_pump_first));
				check_field("refill_pump_second", int'(pending_results[0].refill_pump_second),
					int'(result_if.data.refill_pump_second));
				check_field("filling", int'(pending_results[0].filling),
					int'(result_if.data.filling));
				check_field("error_class", int'(pending_results[0].error_class),
					int'(result_if.data.error_class));
				check_field("error_urgent", int'(pending_results[0].error_urgent),
					int'(result_if.data.error_urgent));
				void'(pending_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sensor_if.valid && sensor_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int cur_sel;
		int level;
		int r;
		tlpc_in_t it;
		tlpc_in_t mixed;
		sensor_if.valid <= 1'b0;
		sensor_if.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		dir_cfg[0] = cfg_of(30, 80, 50, 15, 900, 1900, 0);
		dir_cfg[1] = cfg_of(30, 80, 50, 15, 2000, 2000, 0);
		dir_cfg[2] = cfg_of(30, 80, 50, 15, 3000, 1000, 0);
		dir_cfg[3] = cfg_of(127, 127, 127, 127, 0, 4095, 1);
		dir_cfg[4] = cfg_of(0, 0, 0, 0, 4095, 0, 0);
		dir_cfg[5] = cfg_of(25, 85, 100, 0, 2000, 2001, 1);
		dir_cfg[6] = cfg_of(30, 80, 50, 15, 900, 1900, 1);
		model_cfg = dir_cfg[0];

		mixed = flat(0, 1'b1);
		mixed.sample_b = 12'd4095;
		mixed.sample_c = 12'd1;
		mixed.sample_d = 12'd2048;
		mixed.sample_e = 12'd1234;

		add_row(0, flat(900, 1'b0), 1'b1, outcome(0, 0, 0, 0, 0, 0, ERR_LOW));
		add_row(0, flat(3300, 1'b0), 1'b1, outcome(240, 1, 1, 0, 0, 0, ERR_HIGH));
		add_row(0, flat(0, 1'b1), 1'b1, outcome(-90, 0, 0, 0, 0, 0, ERR_FAULT));
		add_row(0, flat(4095, 1'b0), 1'b1, outcome(319, 1, 1, 0, 0, 0, ERR_HIGH));
		add_row(0, flat(1300, 1'b0), 1'b0, '0);
		add_row(0, flat(1350, 1'b1), 1'b0, '0);
		add_row(0, flat(1400, 1'b0), 1'b0, '0);
		add_row(0, flat(1300, 1'b0), 1'b0, '0);
		add_row(0, flat(1200, 1'b0), 1'b0, '0);
		add_row(0, flat(1210, 1'b0), 1'b0, '0);
		add_row(0, flat(1650, 1'b0), 1'b0, '0);
		add_row(0, flat(1700, 1'b0), 1'b0, '0);
		add_row(0, mixed, 1'b0, '0);
		add_row(1, flat(2000, 1'b0), 1'b1, outcome(0, 0, 0, 0, 0, 0, ERR_FAULT));
		add_row(1, flat(0, 1'b1), 1'b0, '0);
		add_row(2, flat(2000, 1'b0), 1'b0, '0);
		add_row(2, flat(3300, 1'b0), 1'b0, '0);
		add_row(2, flat(0, 1'b0), 1'b0, '0);
		add_row(3, flat(4095, 1'b1), 1'b0, '0);
		add_row(4, flat(4095, 1'b0), 1'b0, '0);
		add_row(4, flat(0, 1'b0), 1'b0, '0);
		add_row(5, flat(4095, 1'b0), 1'b0, '0);
		add_row(5, flat(0, 1'b0), 1'b0, '0);
		add_row(5, flat(2000, 1'b1), 1'b0, '0);
		add_row(6, flat(1300, 1'b1), 1'b0, '0);
		add_row(6, flat(1500, 1'b1), 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		cur_sel = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg_sel != cur_sel) begin
				drain();
				apply_config(dir_cfg[dir_rows[i].cfg_sel]);
				cur_sel = dir_rows[i].cfg_sel;
			end
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			apply_config(ph == 0 ? dir_cfg[0] : random_cfg());
			steady = (ph == 1);
			if (ph == 3)
				hold_req = 1'b1;
			level = $urandom_range(0, 100);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					it = tlpc_in_t'({$urandom, $urandom});
				end else begin
					if (r < 13)
						level = int'($urandom_range(0, 190)) - 40;
					else
						level += int'($urandom_range(0, 12)) - 6;
					if (level < -40) level = -40;
					if (level > 180) level = 180;
					it = near_level(level, $urandom_range(0, 5) == 0);
				end
				send_item(it, 1'b0, '0);
			end
			steady = 1'b0;
		end

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
